>>> sv/saps_pkg.sv
// shared types and constants for the axis position sequencer
package saps_pkg;

  localparam int AXES = 6;
  localparam int AXW  = 3;
  localparam int BACKLASH_MARGIN = 4;
  localparam int FINE_WINDOW = 2;

  typedef enum logic [3:0] {
    OP_TICK = 4'd0, OP_STAGE = 4'd1, OP_COMMIT_REL = 4'd2, OP_COMMIT_ENC = 4'd3,
    OP_SINGLE = 4'd4, OP_STOP_AXIS = 4'd5, OP_STOP_ALL = 4'd6, OP_CHASE_ON = 4'd7,
    OP_CHASE_OFF = 4'd8
  } opcode_t;

  localparam logic [2:0] M_STANDBY = 3'd0;
  localparam logic [2:0] M_CHASE   = 3'd1;
  localparam logic [2:0] M_STEP    = 3'd2;
  localparam logic [2:0] M_QUICK   = 3'd3;
  localparam logic [2:0] M_FINE    = 3'd4;

  localparam logic [1:0] REG_MAX_STEPS = 2'd0;
  localparam logic [1:0] REG_FORCE_GAIN = 2'd1;
  localparam logic [1:0] REG_ENC_GAIN = 2'd2;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [2:0]         axis;
    logic signed [31:0] value;
    logic signed [31:0] encoder_now;
    logic signed [31:0] force_now;
    logic               low_switch;
    logic               high_switch;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [2:0]         axis_out;
    logic signed [15:0] steps_out;
    logic [2:0]         mode_out;
    logic signed [31:0] queued_out;
    logic               low_limit_hit;
    logic               high_limit_hit;
    logic               unstable;
    logic [15:0]        unstable_count;
  } out_item_t;

  // divider request and status between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [46:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [46:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/saps_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module saps_div
  import saps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [46:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  // load on start, else one shift-subtract step
  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[46]} - {2'b00, den_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
      cnt_nxt  = 6'd47;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        quo_nxt = {quo_r[45:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], quo_r[46]};
        quo_nxt = {quo_r[45:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

>>> sv/stepper_axis_position_sequencer_core.sv
// top level of the axis position sequencer: registers, state and sequencer
//
// One transaction is taken while busy is low and start is high; its result appears
// on out_valid for one cycle. A tick, stage, stop or chase command goes from execute
// straight to the result. A commit or single move first walks the six axes for the
// largest queued magnitude, then rescales all axis limits through one shared
// 47-step restoring divider, one axis after another; when nothing is queued, all
// limits are set to one instead. Results cannot be held off by the receiver.
module stepper_axis_position_sequencer_core
  import saps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_EXEC = 6'b000010, S_MAX = 6'b000100,
    S_DIV  = 6'b001000, S_WAIT = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0]        max_steps_r;
  logic signed [23:0] force_gain_r;
  logic [9:0]         enc_gain_r;

  logic [2:0]         mode_r    [AXES];
  logic signed [31:0] queued_r  [AXES];
  logic [15:0]        limit_r   [AXES];
  logic signed [31:0] target_r  [AXES];
  logic signed [31:0] staged_r  [AXES];
  logic signed [31:0] lastenc_r [AXES];
  logic [7:0]         stable_r  [AXES];
  logic [15:0]        unstab_r  [AXES];
  logic signed [15:0] lastst_r  [AXES];

  in_item_t  item_r;
  out_item_t res_r;
  logic      valid_r;
  logic [AXW-1:0] idx_r;
  logic [31:0]    mx_r;
  div_req_t  dreq;
  div_rsp_t  drsp;

  logic [AXW-1:0] a;
  logic           ok;
  assign a  = item_r.axis;
  assign ok = (item_r.axis < 3'(AXES));

  // configuration port
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_MAX_STEPS:  cfg_prdata = {17'd0, max_steps_r};
      REG_FORCE_GAIN: cfg_prdata = {{8{force_gain_r[23]}}, force_gain_r};
      REG_ENC_GAIN:   cfg_prdata = {22'd0, enc_gain_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_steps_r  <= 15'd100;
      force_gain_r <= '0;
      enc_gain_r   <= 10'd1;
    end else if (cfg_wr) begin
      if (cfg_paddr[3:2] == REG_MAX_STEPS) max_steps_r <= cfg_pwdata[14:0];
      if (cfg_paddr[3:2] == REG_FORCE_GAIN) force_gain_r <= cfg_pwdata[23:0];
      if (cfg_paddr[3:2] == REG_ENC_GAIN) enc_gain_r <= cfg_pwdata[9:0];
    end
  end

  saps_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // tick arithmetic for the addressed axis
  logic signed [55:0] chase_p;
  logic [55:0]        chase_m;
  logic signed [16:0] st_tick;
  logic signed [32:0] fine_d;
  logic signed [43:0] fine_s;
  logic signed [32:0] q_clamp;
  logic signed [16:0] lim_s, max_s;
  logic               fine_small;
  logic [7:0]         stable_new;
  logic signed [32:0] enc_d, enc_dm;
  logic signed [43:0] enc_q;
  logic signed [31:0] enc_qs;

  always_comb begin
    max_s   = {2'b00, max_steps_r};
    lim_s   = {1'b0, limit_r[a]};
    chase_p = 56'(item_r.force_now) * 56'(force_gain_r);
    chase_m = chase_p[55] ? 56'(-chase_p) : chase_p;
    chase_m = chase_m >> 24;
    fine_d  = 33'(target_r[a]) - 33'(item_r.encoder_now);
    fine_s  = 44'(fine_d) * $signed({34'd0, enc_gain_r});
    fine_small = (fine_d >= -33'(FINE_WINDOW)) && (fine_d <= 33'(FINE_WINDOW));
    q_clamp = 33'(queued_r[a]);
    stable_new = stable_r[a];
    st_tick = '0;
    unique case (mode_r[a])
      M_CHASE: begin
        st_tick = (chase_m > 56'(max_steps_r)) ? max_s : 17'(chase_m);
        if (chase_p[55]) st_tick = -st_tick;
      end
      M_STEP, M_QUICK: begin
        if (q_clamp > 33'(lim_s)) st_tick = lim_s;
        else if (q_clamp < -33'(lim_s)) st_tick = -lim_s;
        else st_tick = 17'(q_clamp);
      end
      M_FINE: begin
        if (fine_small) begin
          if (fine_d != 0) begin
            st_tick = fine_d[32] ? -17'sd1 : 17'sd1;
            stable_new = '0;
          end else if (stable_r[a] != 8'd255) begin
            stable_new = stable_r[a] + 8'd1;
          end
          if (max_steps_r == 15'd0) st_tick = '0;
        end else if (fine_s > 44'(max_s)) st_tick = max_s;
        else if (fine_s < -44'(max_s)) st_tick = -max_s;
        else st_tick = 17'(fine_s);
        if (fine_d == 0 && stable_new >= 8'd2) st_tick = '0;
      end
      default: st_tick = '0;
    endcase
    // encoder commit for the axis being walked
    enc_d = 33'(staged_r[idx_r]) - 33'(lastenc_r[idx_r]);
    if (enc_d > 0) enc_dm = (enc_d > 33'(BACKLASH_MARGIN)) ? enc_d - 33'(BACKLASH_MARGIN) : '0;
    else if (enc_d < 0) enc_dm = (enc_d < -33'(BACKLASH_MARGIN)) ? enc_d + 33'(BACKLASH_MARGIN) : '0;
    else enc_dm = '0;
    enc_q = 44'(enc_dm) * $signed({34'd0, enc_gain_r});
    if (enc_q > 44'sd2147483647) enc_qs = 32'sh7fffffff;
    else if (enc_q < -44'sd2147483648) enc_qs = 32'sh80000000;
    else enc_qs = 32'(enc_q);
  end

  // busy-check terms for commits and chase-on
  logic rel_block, enc_block, chase_block;
  always_comb begin
    rel_block = 1'b0; enc_block = 1'b0; chase_block = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      if (mode_r[i] != M_STANDBY && staged_r[i] != 0) rel_block = 1'b1;
      if (mode_r[i] != M_STANDBY && staged_r[i] != lastenc_r[i]) enc_block = 1'b1;
      if (mode_r[i] != M_STANDBY) chase_block = 1'b1;
    end
  end

  logic lo_hit, hi_hit;
  assign lo_hit = st_tick[16] && item_r.low_switch;
  assign hi_hit = !st_tick[16] && (st_tick != 0) && item_r.high_switch;

  // sequencer
  logic do_scale, acc;
  always_comb begin
    state_nxt = state_r;
    dreq.start = 1'b0;
    dreq.dividend = 47'(max_steps_r) * 47'(mag32(queued_r[idx_r]));
    dreq.divisor  = mx_r;
    do_scale = 1'b0;
    acc = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: begin
        unique case (item_r.opcode)
          OP_TICK, OP_STAGE, OP_STOP_AXIS: acc = ok;
          OP_COMMIT_REL: begin acc = !rel_block; do_scale = acc; end
          OP_COMMIT_ENC: begin acc = !enc_block; do_scale = acc; end
          OP_SINGLE: begin acc = ok && item_r.value != 0; do_scale = acc; end
          OP_STOP_ALL, OP_CHASE_OFF: acc = 1'b1;
          OP_CHASE_ON: acc = !chase_block;
          default: acc = 1'b0;
        endcase
        state_nxt = do_scale ? S_MAX : S_OUT;
      end
      S_MAX: if (idx_r == AXW'(AXES - 1)) state_nxt = S_DIV;
      S_DIV: begin
        if (mx_r == 0) state_nxt = S_OUT;
        else begin dreq.start = 1'b1; state_nxt = S_WAIT; end
      end
      S_WAIT: if (drsp.done) state_nxt = (idx_r == AXW'(AXES - 1)) ? S_OUT : S_DIV;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result fields fixed at execute time, axis state added on the way out
  out_item_t res_exec, res_done;
  always_comb begin
    res_exec          = '0;
    res_exec.accepted = acc;
    res_exec.axis_out = item_r.axis;
    if (acc && item_r.opcode == OP_TICK) begin
      res_exec.steps_out      = (lo_hit || hi_hit) ? '0 : 16'(st_tick);
      res_exec.low_limit_hit  = lo_hit;
      res_exec.high_limit_hit = hi_hit;
      if (mode_r[a] == M_FINE && !fine_small) begin
        res_exec.unstable       = 1'b1;
        res_exec.unstable_count = unstab_r[a];
      end
    end
    res_done            = res_r;
    res_done.mode_out   = ok ? mode_r[a] : '0;
    res_done.queued_out = ok ? queued_r[a] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      idx_r   <= '0;
      for (int i = 0; i < AXES; i++) begin
        mode_r[i] <= M_STANDBY; queued_r[i] <= '0; limit_r[i] <= 16'd100;
        target_r[i] <= '0; staged_r[i] <= '0; lastenc_r[i] <= '0;
        stable_r[i] <= '0; unstab_r[i] <= '0; lastst_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      valid_r <= (state_r == S_OUT);
      unique case (state_r)
        S_IDLE: if (start) item_r <= in_item;
        S_EXEC: begin
          res_r <= res_exec;
          idx_r <= '0;
          mx_r  <= '0;
          if (acc) begin
            unique case (item_r.opcode)
              OP_TICK: begin
                lastst_r[a] <= (lo_hit || hi_hit) ? '0 : 16'(st_tick);
                lastenc_r[a] <= item_r.encoder_now;
                unique case (mode_r[a])
                  M_CHASE: ;
                  M_STEP, M_QUICK: begin
                    queued_r[a] <= queued_r[a] - 32'(st_tick);
                    if (queued_r[a] == 0)
                      mode_r[a] <= (mode_r[a] == M_STEP) ? M_STANDBY : M_FINE;
                  end
                  M_FINE: begin
                    stable_r[a] <= stable_new;
                    if (fine_small) unstab_r[a] <= '0;
                    else if (unstab_r[a] != 16'hffff) unstab_r[a] <= unstab_r[a] + 16'd1;
                    if (fine_d == 0 && stable_new >= 8'd2) mode_r[a] <= M_STANDBY;
                  end
                  default: begin
                    mode_r[a] <= M_STANDBY; queued_r[a] <= '0;
                  end
                endcase
              end
              OP_STAGE: staged_r[a] <= item_r.value;
              OP_COMMIT_REL:
                for (int i = 0; i < AXES; i++) begin
                  queued_r[i] <= staged_r[i];
                  mode_r[i] <= (staged_r[i] != 0) ? M_STEP : M_STANDBY;
                end
              OP_COMMIT_ENC: ;
              OP_SINGLE: begin queued_r[a] <= item_r.value; mode_r[a] <= M_STEP; end
              OP_STOP_AXIS: begin queued_r[a] <= '0; mode_r[a] <= M_STANDBY; end
              OP_STOP_ALL:
                for (int i = 0; i < AXES; i++) begin
                  queued_r[i] <= '0; mode_r[i] <= M_STANDBY;
                end
              OP_CHASE_ON: for (int i = 0; i < AXES; i++) mode_r[i] <= M_CHASE;
              OP_CHASE_OFF: for (int i = 0; i < AXES; i++) mode_r[i] <= M_STANDBY;
              default: ;
            endcase
          end
        end
        // walk axes: apply any encoder commit, then find the largest magnitude
        S_MAX: begin
          if (item_r.opcode == OP_COMMIT_ENC) begin
            target_r[idx_r] <= staged_r[idx_r];
            stable_r[idx_r] <= '0;
            unstab_r[idx_r] <= '0;
            queued_r[idx_r] <= enc_qs;
            mode_r[idx_r]   <= (enc_qs != 0) ? M_QUICK : M_STANDBY;
            if (mag32(enc_qs) > mx_r) mx_r <= mag32(enc_qs);
          end else if (mag32(queued_r[idx_r]) > mx_r) begin
            mx_r <= mag32(queued_r[idx_r]);
          end
          idx_r <= (idx_r == AXW'(AXES - 1)) ? '0 : idx_r + AXW'(1);
        end
        S_DIV: if (mx_r == 0) for (int i = 0; i < AXES; i++) limit_r[i] <= 16'd1;
        S_WAIT: if (drsp.done) begin
          limit_r[idx_r] <= (drsp.quotient == 0) ? 16'd1 : 16'(drsp.quotient);
          idx_r <= idx_r + AXW'(1);
        end
        S_OUT: res_r <= res_done;
        default: ;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;
  assign out_item  = res_r;

endmodule

>>> sv/saps_checker.sv
// port-level checks for the axis position sequencer, bound to the top level
module saps_checker
  import saps_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // a result never shows without the block having been busy
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");

  // a transaction starts work on the next cycle
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transaction not taken");

  // result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");

  // the two limit flags are never set together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.low_limit_hit && out_item.high_limit_hit))
    else $error("both limit flags");

endmodule

bind stepper_axis_position_sequencer_core saps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
